FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/bcrp_pkg.sv
package bcrp_pkg;

  localparam logic [7:0] TYPE_MASK   = 8'h0F;
  localparam logic [7:0] ADV_TYPE    = 8'h05;
  localparam logic [7:0] PAYLOAD_LEN = 8'd34;
  localparam logic [7:0] HOP_MASK    = 8'h1F;

  localparam int unsigned POS_HDR_LEN     = 1;
  localparam int unsigned POS_ADDR_FIRST  = 9;
  localparam int unsigned POS_ADDR_LAST   = 14;
  localparam int unsigned POS_FIELD_FIRST = 15;
  localparam int unsigned POS_FIELD_LAST  = 36;
  localparam int unsigned POS_MIN_LAST    = 36;

  localparam int unsigned FIELD_BYTES = POS_FIELD_LAST - POS_FIELD_FIRST + 1;
  localparam int unsigned SLOT_W      = $clog2(FIELD_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_NOT_CONNECT   = 2'd0;
  localparam logic [1:0] STATUS_ADDR_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_ACCEPTED      = 2'd2;

  typedef struct packed {
    logic [7:0]        rx_byte;
    logic              field_en;
    logic [SLOT_W-1:0] slot;
    logic              hdr_bad;
    logic              addr_bad;
    logic              short_pkt;
    logic              crc_ok;
    logic              last_byte;
  } bcrp_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] access_address;
    logic [23:0] crc_init;
    logic [7:0]  window_size;
    logic [15:0] window_offset;
    logic [15:0] connection_interval;
    logic [15:0] supervision_timeout;
    logic [39:0] channel_map;
    logic [4:0]  hop_increment;
  } bcrp_result_t;

endpackage

FILE: hw/rtl/bcrp_ifs.sv
interface bcrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       crc_ok;
  logic       last_byte;

  modport source (output valid, output rx_byte, output crc_ok, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input crc_ok, input last_byte, output ready);
endinterface

interface bcrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] access_address;
  logic [23:0] crc_init;
  logic [7:0]  window_size;
  logic [15:0] window_offset;
  logic [15:0] connection_interval;
  logic [15:0] supervision_timeout;
  logic [39:0] channel_map;
  logic [4:0]  hop_increment;

  modport source (
    output valid, output status, output access_address, output crc_init,
    output window_size, output window_offset, output connection_interval,
    output supervision_timeout, output channel_map, output hop_increment,
    input ready
  );
  modport sink (
    input valid, input status, input access_address, input crc_init,
    input window_size, input window_offset, input connection_interval,
    input supervision_timeout, input channel_map, input hop_increment,
    output ready
  );
endinterface

interface bcrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] own_device_address;

  modport source (output valid, output own_device_address, input ready);
  modport sink (input valid, input own_device_address, output ready);
endinterface

FILE: hw/rtl/ble_connect_request_parser.sv
// Connect request parser for received advertising-channel packets.
// in_ch carries the packet buffer one byte per transfer: S0 header, length,
// S1, then the payload, with last_byte and crc_ok on the final byte.
// cfg_ch writes the 48-bit own device address; it is always ready. The user
// must write it only between packets; the block itself does not enforce this.
// out_ch gives one result per packet, on the transfer of its last byte:
// status 0 (not a connect request), 1 (address mismatch) or 2 (accepted,
// with the parsed connection fields; all fields are zero otherwise).
// Throughput is one byte per cycle while the queue has room. A result becomes
// valid on out_ch once its last byte has passed through the two-entry queue
// between the byte classifier and the field assembler, which then loads the
// output register.
// When out_ch stalls, the result is held, the assembler stops at the next
// last byte, and in_ch ready falls once the queue holds two bytes.
// Reset clears the byte position, the queue, the output valid and the address
// register, and sets the header and address flags back to good.
module ble_connect_request_parser #(
  parameter int unsigned POSITION_LIMIT = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  bcrp_in_if.sink    in_ch,
  bcrp_out_if.source out_ch,
  bcrp_cfg_if.sink   cfg_ch
);
  import bcrp_pkg::*;

  logic         push_valid, push_ready;
  logic         pop_valid, pop_ready;
  bcrp_entry_t  push_entry, pop_entry;
  bcrp_result_t result;

  bcrp_front #(
    .POSITION_LIMIT(POSITION_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_rx_byte   (in_ch.rx_byte),
    .in_crc_ok    (in_ch.crc_ok),
    .in_last_byte (in_ch.last_byte),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.own_device_address),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  bcrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bcrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (result)
  );

  assign out_ch.status              = result.status;
  assign out_ch.access_address      = result.access_address;
  assign out_ch.crc_init            = result.crc_init;
  assign out_ch.window_size         = result.window_size;
  assign out_ch.window_offset       = result.window_offset;
  assign out_ch.connection_interval = result.connection_interval;
  assign out_ch.supervision_timeout = result.supervision_timeout;
  assign out_ch.channel_map         = result.channel_map;
  assign out_ch.hop_increment       = result.hop_increment;

endmodule

FILE: hw/rtl/bcrp_front.sv
module bcrp_front #(
  parameter int unsigned POSITION_LIMIT = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_crc_ok,
  input  logic                in_last_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [47:0]         cfg_data,
  output logic                push_valid,
  input  logic                push_ready,
  output bcrp_pkg::bcrp_entry_t push_entry
);
  import bcrp_pkg::*;

  localparam int unsigned POS_W = $clog2(POSITION_LIMIT + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [47:0]      addr_r;
  logic [2:0]       addr_idx;
  logic [7:0]       addr_byte;
  logic             accept;
  logic             in_addr;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign cfg_ready  = 1'b1;

  always_comb begin
    addr_idx = 3'(pos_r - POS_W'(POS_ADDR_FIRST));
    unique case (addr_idx)
      3'd0:    addr_byte = addr_r[7:0];
      3'd1:    addr_byte = addr_r[15:8];
      3'd2:    addr_byte = addr_r[23:16];
      3'd3:    addr_byte = addr_r[31:24];
      3'd4:    addr_byte = addr_r[39:32];
      default: addr_byte = addr_r[47:40];
    endcase
    in_addr = (pos_r >= POS_W'(POS_ADDR_FIRST)) && (pos_r <= POS_W'(POS_ADDR_LAST));

    push_entry.rx_byte   = in_rx_byte;
    push_entry.field_en  = (pos_r >= POS_W'(POS_FIELD_FIRST)) &&
                           (pos_r <= POS_W'(POS_FIELD_LAST));
    push_entry.slot      = SLOT_W'(pos_r - POS_W'(POS_FIELD_FIRST));
    push_entry.hdr_bad   = ((pos_r == '0) && ((in_rx_byte & TYPE_MASK) != ADV_TYPE)) ||
                           ((pos_r == POS_W'(POS_HDR_LEN)) && (in_rx_byte != PAYLOAD_LEN));
    push_entry.addr_bad  = in_addr && (in_rx_byte != addr_byte);
    push_entry.short_pkt = pos_r < POS_W'(POS_MIN_LAST);
    push_entry.crc_ok    = in_crc_ok;
    push_entry.last_byte = in_last_byte;

    pos_nxt = pos_r;
    if (accept) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (pos_r < POS_W'(POSITION_LIMIT)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      addr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_valid) begin
        addr_r <= cfg_data;
      end
    end
  end

endmodule

FILE: hw/rtl/bcrp_queue.sv
`include "assert_macros.svh"

module bcrp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  bcrp_pkg::bcrp_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output bcrp_pkg::bcrp_entry_t pop_entry
);
  import bcrp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bcrp_entry_t      q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire, pop_fire;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = q_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `ASSERT_NEXT(a_count_up, clk, rst_n, push_fire && !pop_fire, count_r == CNT_W'($past(count_r) + 1'b1), "queue count did not rise on push")
  `ASSERT_NEXT(a_count_down, clk, rst_n, pop_fire && !push_fire, count_r == CNT_W'($past(count_r) - 1'b1), "queue count did not fall on pop")

endmodule

FILE: hw/rtl/bcrp_back.sv
module bcrp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  bcrp_pkg::bcrp_entry_t  pop_entry,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bcrp_pkg::bcrp_result_t out_result
);
  import bcrp_pkg::*;

  logic         hv_r, ae_r;
  logic         hv, ae;
  logic [7:0]   acc_r   [FIELD_BYTES];
  logic [7:0]   acc_nxt [FIELD_BYTES];
  logic         out_valid_r;
  bcrp_result_t res_r, res_nxt;
  logic         fire;
  logic [7:0]   hop_byte;

  assign pop_ready  = !pop_entry.last_byte || !out_valid_r || out_ready;
  assign fire       = pop_valid && pop_ready;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  always_comb begin
    acc_nxt = acc_r;
    if (pop_entry.field_en) begin
      acc_nxt[pop_entry.slot] = pop_entry.rx_byte;
    end
    hv       = hv_r && !pop_entry.hdr_bad;
    ae       = ae_r && !pop_entry.addr_bad;
    hop_byte = acc_nxt[21] & HOP_MASK;

    res_nxt = '0;
    if (!hv || !pop_entry.crc_ok || pop_entry.short_pkt) begin
      res_nxt.status = STATUS_NOT_CONNECT;
    end else if (!ae) begin
      res_nxt.status = STATUS_ADDR_MISMATCH;
    end else begin
      res_nxt.status              = STATUS_ACCEPTED;
      res_nxt.access_address      = {acc_nxt[3], acc_nxt[2], acc_nxt[1], acc_nxt[0]};
      res_nxt.crc_init            = {acc_nxt[6], acc_nxt[5], acc_nxt[4]};
      res_nxt.window_size         = acc_nxt[7];
      res_nxt.window_offset       = {acc_nxt[9], acc_nxt[8]};
      res_nxt.connection_interval = {acc_nxt[11], acc_nxt[10]};
      res_nxt.supervision_timeout = {acc_nxt[15], acc_nxt[14]};
      res_nxt.channel_map         = {acc_nxt[20], acc_nxt[19], acc_nxt[18],
                                     acc_nxt[17], acc_nxt[16]};
      res_nxt.hop_increment       = hop_byte[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r <= acc_nxt;
    end
    if (fire && pop_entry.last_byte) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= 1'b1;
      ae_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        hv_r <= pop_entry.last_byte ? 1'b1 : hv;
        ae_r <= pop_entry.last_byte ? 1'b1 : ae;
      end
      if (fire && pop_entry.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: dv/bcrp_checker.sv
module bcrp_checker (
  input  logic clk,
  input  logic rst_n,
  bcrp_in_if   in_mon,
  bcrp_out_if  out_mon,
  bcrp_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import bcrp_pkg::*;

  localparam int unsigned POSITION_LIMIT = 63;

  int unsigned  byte_pos;
  logic         hdr_good;
  logic         addr_match;
  logic [63:0]  link_fields [3];
  logic [47:0]  own_addr;
  bcrp_result_t verdict_q [$];

  task automatic clear_packet();
    byte_pos = 0;
    hdr_good = 1'b1;
    addr_match = 1'b1;
    foreach (link_fields[k]) link_fields[k] = '0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    $display("checker: %s got %0h want %0h", what, got, want);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic crc, input logic last);
    bcrp_result_t r;
    int unsigned p;
    p = byte_pos;
    if (p == 0) begin
      if ((b & TYPE_MASK) != ADV_TYPE) hdr_good = 1'b0;
    end else if (p == POS_HDR_LEN) begin
      if (b != PAYLOAD_LEN) hdr_good = 1'b0;
    end else if (p >= POS_ADDR_FIRST && p <= POS_ADDR_LAST) begin
      if (b != own_addr[8*(p-POS_ADDR_FIRST) +: 8]) addr_match = 1'b0;
    end else if (p >= POS_FIELD_FIRST && p <= POS_FIELD_LAST) begin
      link_fields[(p-POS_FIELD_FIRST)/8][8*((p-POS_FIELD_FIRST)%8) +: 8] = b;
    end
    if (byte_pos < POSITION_LIMIT) byte_pos++;
    if (last) begin
      r = '0;
      if (!hdr_good || !crc || p < POS_MIN_LAST) begin
        r.status = STATUS_NOT_CONNECT;
      end else if (!addr_match) begin
        r.status = STATUS_ADDR_MISMATCH;
      end else begin
        r.status = STATUS_ACCEPTED;
        r.access_address = link_fields[0][31:0];
        r.crc_init = link_fields[0][55:32];
        r.window_size = link_fields[0][63:56];
        r.window_offset = link_fields[1][15:0];
        r.connection_interval = link_fields[1][31:16];
        r.supervision_timeout = link_fields[1][63:48];
        r.channel_map = link_fields[2][39:0];
        r.hop_increment = link_fields[2][44:40];
      end
      verdict_q.push_back(r);
      clear_packet();
    end
  endtask

  task automatic check_result();
    bcrp_result_t r;
    if (verdict_q.size() == 0) begin
      report("result with none expected, status", 64'(out_mon.status), '0);
    end else begin
      r = verdict_q.pop_front();
      if (out_mon.status != r.status) begin
        report("status", 64'(out_mon.status), 64'(r.status));
      end
      if (out_mon.access_address != r.access_address) begin
        report("access_address", 64'(out_mon.access_address), 64'(r.access_address));
      end
      if (out_mon.crc_init != r.crc_init) begin
        report("crc_init", 64'(out_mon.crc_init), 64'(r.crc_init));
      end
      if (out_mon.window_size != r.window_size) begin
        report("window_size", 64'(out_mon.window_size), 64'(r.window_size));
      end
      if (out_mon.window_offset != r.window_offset) begin
        report("window_offset", 64'(out_mon.window_offset), 64'(r.window_offset));
      end
      if (out_mon.connection_interval != r.connection_interval) begin
        report("connection_interval", 64'(out_mon.connection_interval),
               64'(r.connection_interval));
      end
      if (out_mon.supervision_timeout != r.supervision_timeout) begin
        report("supervision_timeout", 64'(out_mon.supervision_timeout),
               64'(r.supervision_timeout));
      end
      if (out_mon.channel_map != r.channel_map) begin
        report("channel_map", 64'(out_mon.channel_map), 64'(r.channel_map));
      end
      if (out_mon.hop_increment != r.hop_increment) begin
        report("hop_increment", 64'(out_mon.hop_increment), 64'(r.hop_increment));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_packet();
      own_addr = '0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) own_addr = cfg_mon.own_device_address;
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.rx_byte, in_mon.crc_ok, in_mon.last_byte);
      end
    end
    pending = verdict_q.size();
  end
endmodule

FILE: dv/tb.sv
module tb;
  import bcrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum int {
    REQ_ACCEPT, REQ_MISMATCH, REQ_BAD_CRC, REQ_BAD_TYPE, REQ_BAD_LEN, REQ_SHORT, REQ_LONG
  } req_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          fails;
  int          pending;
  int          send_idle;
  int          recv_idle;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  logic [47:0] own_addr;

  bcrp_in_if  in_ch ();
  bcrp_out_if out_ch ();
  bcrp_cfg_if cfg_ch ();

  ble_connect_request_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bcrp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic push_byte(input logic [7:0] b, input logic crc, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.crc_ok <= crc;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_address(input logic [47:0] addr);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.own_device_address <= addr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    own_addr = addr;
  endtask

  // A negative fill gives random content; the header and address bytes are
  // shaped by the flags on top of it.
  task automatic send_request(input int unsigned len, input bit type_ok, input bit len_ok,
                              input bit addr_ok, input bit crc, input int fill);
    logic [7:0]  b;
    logic [3:0]  nib;
    int unsigned bad_pos;
    bad_pos = $urandom_range(POS_ADDR_LAST, POS_ADDR_FIRST);
    for (int unsigned i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) begin
        if (type_ok) begin
          b = (b & ~TYPE_MASK) | ADV_TYPE;
        end else begin
          nib = 4'($urandom_range(14));
          if (nib >= 4'(ADV_TYPE)) nib++;
          b = {b[7:4], nib};
        end
      end else if (i == POS_HDR_LEN) begin
        if (len_ok) begin
          b = PAYLOAD_LEN;
        end else begin
          b = 8'($urandom_range(254));
          if (b >= PAYLOAD_LEN) b++;
        end
      end else if (i >= POS_ADDR_FIRST && i <= POS_ADDR_LAST) begin
        b = own_addr[8*(i-POS_ADDR_FIRST) +: 8];
        if (!addr_ok && i == bad_pos) b ^= 8'($urandom_range(255, 1));
      end
      push_byte(b, (i == len - 1) ? crc : 1'($urandom), i == len - 1);
    end
  endtask

  task automatic send_kind(input req_kind_t kind);
    int unsigned full;
    full = POS_FIELD_LAST + 1;
    unique case (kind)
      REQ_ACCEPT:   send_request(full, 1, 1, 1, 1, -1);
      REQ_MISMATCH: send_request(full, 1, 1, 0, 1, -1);
      REQ_BAD_CRC:  send_request(full, 1, 1, 1'($urandom_range(1)), 0, -1);
      REQ_BAD_TYPE: begin
        send_request(full, 0, 1'($urandom_range(1)), 1'($urandom_range(1)), 1, -1);
      end
      REQ_BAD_LEN: begin
        send_request(full, 1, 0, 1'($urandom_range(1)), 1'($urandom_range(1)), -1);
      end
      REQ_SHORT: begin
        send_request($urandom_range(POS_MIN_LAST, 1), $urandom_range(3) != 0,
                     $urandom_range(3) != 0, 1, $urandom_range(3) != 0, -1);
      end
      default: begin
        send_request($urandom_range(90, full + 1), 1, 1, $urandom_range(3) != 0,
                     $urandom_range(3) != 0, -1);
      end
    endcase
  endtask

  function automatic req_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return REQ_ACCEPT;
    if (roll < 65) return REQ_MISMATCH;
    if (roll < 73) return REQ_BAD_CRC;
    if (roll < 79) return REQ_BAD_TYPE;
    if (roll < 85) return REQ_BAD_LEN;
    if (roll < 93) return REQ_SHORT;
    return REQ_LONG;
  endfunction

  function automatic logic [47:0] pick_address();
    unique case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {32'($urandom), 16'($urandom)};
    endcase
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.crc_ok = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.own_device_address = '0;
    own_addr = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_address('1);
    send_request(POS_FIELD_LAST + 1, 1, 1, 1, 1, 0);
    send_request(POS_FIELD_LAST + 1, 1, 1, 1, 1, 255);
    send_request(POS_FIELD_LAST + 1, 1, 1, 0, 1, -1);
    send_request(POS_FIELD_LAST + 1, 1, 1, 1, 0, -1);
    send_request(POS_FIELD_LAST + 1, 0, 1, 1, 1, -1);
    send_request(POS_FIELD_LAST + 1, 1, 0, 1, 1, -1);
    send_request(1, 1, 1, 1, 1, -1);
    send_request(POS_MIN_LAST, 1, 1, 1, 1, -1);
    send_request(80, 1, 1, 1, 1, -1);
    write_address('0);
    send_request(POS_FIELD_LAST + 1, 1, 1, 1, 1, 255);
    send_request(POS_FIELD_LAST + 1, 0, 0, 0, 0, 0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 6 : (mode == 1) ? 79 : 0;
      recv_idle = (mode == 0) ? 79 : (mode == 1) ? 6 : 0;
      while (bytes_sent < 400 + 250 * (mode + 1)) begin
        write_address(pick_address());
        repeat ($urandom_range(8, 3)) send_kind(pick_kind());
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bcrp_pkg.sv
hw/rtl/bcrp_ifs.sv
hw/rtl/bcrp_front.sv
hw/rtl/bcrp_queue.sv
hw/rtl/bcrp_back.sv
hw/rtl/ble_connect_request_parser.sv
dv/bcrp_checker.sv
dv/tb.sv
